// ===== hw/rtl/bbah_pkg.sv =====
// bbah_pkg: shared widths, codes and controller/datapath structs
// for the bitmap block allocator; no dependencies
`default_nettype none

package bbah_pkg;

	localparam int MAX_BLOCKS_DEF     = 256;
	localparam int SCAN_WORD_BITS_DEF = 32;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam int ST_W   = 3;

	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

	// stream packing
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_OK_LSB     = 0;
	localparam int OUT_GRANT_LSB  = 1;
	localparam int OUT_HINT_LSB   = 9;
	localparam int OUT_STATUS_LSB = 10;
	localparam int OUT_USED_LSB   = 13;
	localparam int OUT_RAW_W      = 22;
	localparam int OUT_TDATA_W    = 24;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_NONE   = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_OOR    = 3'd4,
		ST_DOUBLE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RD_HINT      = 3'd0,
		RD_FIRST     = 3'd1,
		RD_SCAN_NEXT = 3'd2,
		RD_CUR_NEXT  = 3'd3,
		RD_IDX       = 3'd4
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE      = 2'd0,
		WR_SET_CUR   = 2'd1,
		WR_SET_FOUND = 2'd2,
		WR_CLR_CUR   = 2'd3
	} wr_op_t;

	typedef struct packed {
		logic    take;
		logic    rd_en;
		rd_sel_t rd_sel;
		wr_op_t  wr_op;
		logic    hint_next;
		logic    clear_all;
		logic    res_set;
		status_t res_status;
		logic    res_ok;
		logic    res_grant;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  empty;
		logic  idx_oor;
		logic  hint_ok;
		logic  cur_free;
		logic  nxt_free;
		logic  found;
		logic  scan_last;
		logic  nxt_in_range;
		logic  nxt_same_word;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bbah_ram.sv =====
// bbah_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module bbah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bbah_dp.sv =====
// bbah_dp: allocator datapath: bitmap ram with row valid bits, count, hint,
// word scan, result and output registers; depends on bbah_pkg, bbah_ram
`default_nettype none

module bbah_dp
	import bbah_pkg::*;
#(
	parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
	parameter int SCAN_WORD_BITS = SCAN_WORD_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire mode_t            in_mode,
	input  wire logic [IDX_W-1:0] in_idx,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_ok,
	output logic [IDX_W-1:0]      out_granted,
	output logic                  out_hint,
	output status_t               out_status,
	output logic [CNT_W-1:0]      out_used
);

	// word size must be a power of two
	localparam int SH     = $clog2(SCAN_WORD_BITS);
	localparam int NWORDS = (MAX_BLOCKS + SCAN_WORD_BITS - 1) / SCAN_WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IW     = AW + SH;
	localparam int CW     = (IW > CNT_W) ? IW : CNT_W;
	localparam int SAT    = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
	localparam logic [CNT_W-1:0] N_SAT = CNT_W'(SAT);

	logic [CNT_W-1:0]          block_count_q;
	mode_t                     mode_q;
	logic [IDX_W-1:0]          idx_q;
	logic [CNT_W-1:0]          in_use_q;
	logic [IDX_W-1:0]          hint_q;
	logic [CNT_W-1:0]          cur_q;
	logic [AW-1:0]             scan_q;
	logic                      hit_q;
	logic [NWORDS-1:0]         valid_q;
	logic                      rvalid_q;
	logic                      res_ok_q;
	status_t                   res_status_q;
	logic                      res_grant_q;

	logic [CNT_W-1:0]          n_eff;
	logic [CNT_W-1:0]          last_w;
	logic [CNT_W-1:0]          cur_nx;
	logic [SH-1:0]             cur_bit;
	logic [SCAN_WORD_BITS-1:0] rdata;
	logic [SCAN_WORD_BITS-1:0] rword;
	logic [SCAN_WORD_BITS-1:0] freev;
	logic [SH-1:0]             pos;
	logic [IW-1:0]             scan_base;
	logic [CNT_W-1:0]          found_idx;
	logic [AW-1:0]             raddr;
	logic [AW-1:0]             waddr;
	logic [SCAN_WORD_BITS-1:0] wdata;
	logic                      we;

	assign n_eff     = (block_count_q > N_SAT) ? N_SAT : block_count_q;
	assign last_w    = (n_eff - CNT_W'(1)) >> SH;
	assign cur_nx    = cur_q + CNT_W'(1);
	assign cur_bit   = cur_q[SH-1:0];
	assign rword     = rvalid_q ? rdata : '0;
	assign scan_base = {scan_q, {SH{1'b0}}};
	assign found_idx = CNT_W'({scan_q, pos});

	// free bits of the scanned word, blocks at or above the count count as used
	always_comb begin
		for (int k = 0; k < SCAN_WORD_BITS; k++) begin
			freev[k] = ~rword[k] && ((CW'(scan_base) + CW'(k)) < CW'(n_eff));
		end
	end

	// lowest free bit
	always_comb begin
		pos = '0;
		for (int k = SCAN_WORD_BITS - 1; k >= 0; k--) begin
			if (freev[k]) begin
				pos = SH'(k);
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_HINT:      raddr = AW'(hint_q >> SH);
			RD_FIRST:     raddr = '0;
			RD_SCAN_NEXT: raddr = scan_q + AW'(1);
			RD_CUR_NEXT:  raddr = AW'(cur_nx >> SH);
			RD_IDX:       raddr = AW'(idx_q >> SH);
			default:      raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = AW'(cur_q >> SH);
		wdata = rword;
		case (cmd.wr_op)
			WR_SET_CUR: begin
				wdata = rword | (SCAN_WORD_BITS'(1) << cur_bit);
			end
			WR_SET_FOUND: begin
				waddr = scan_q;
				wdata = rword | (SCAN_WORD_BITS'(1) << pos);
			end
			WR_CLR_CUR: begin
				wdata = rword & ~(SCAN_WORD_BITS'(1) << cur_bit);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bbah_ram #(
		.WIDTH(SCAN_WORD_BITS),
		.DEPTH(NWORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign stat.mode          = mode_q;
	assign stat.full          = in_use_q >= n_eff;
	assign stat.empty         = in_use_q == '0;
	assign stat.idx_oor       = {1'b0, idx_q} >= n_eff;
	assign stat.hint_ok       = {1'b0, hint_q} < n_eff;
	assign stat.cur_free      = ~rword[cur_bit];
	assign stat.nxt_free      = ~rword[cur_nx[SH-1:0]];
	assign stat.found         = |freev;
	assign stat.scan_last     = CW'(scan_q) >= CW'(last_w);
	assign stat.nxt_in_range  = cur_nx < n_eff;
	assign stat.nxt_same_word = cur_nx[SH-1:0] != '0;
	assign stat.out_free      = ~out_valid | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			in_use_q      <= '0;
			hint_q        <= '0;
			hit_q         <= 1'b0;
			valid_q       <= '0;
			rvalid_q      <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_wdata;
			end
			if (cmd.take) begin
				hit_q <= 1'b0;
			end
			if (cmd.rd_en) begin
				rvalid_q <= valid_q[raddr];
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			case (cmd.wr_op)
				WR_SET_CUR: begin
					in_use_q <= in_use_q + CNT_W'(1);
					hit_q    <= 1'b1;
				end
				WR_SET_FOUND: begin
					in_use_q <= in_use_q + CNT_W'(1);
				end
				WR_CLR_CUR: begin
					in_use_q <= in_use_q - CNT_W'(1);
					hint_q   <= cur_q[IDX_W-1:0];
				end
				default: begin
				end
			endcase
			if (cmd.hint_next) begin
				hint_q <= cur_nx[IDX_W-1:0];
			end
			if (cmd.clear_all) begin
				valid_q  <= '0;
				in_use_q <= '0;
				hint_q   <= '0;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= in_mode;
			idx_q  <= in_idx;
		end
		if (cmd.rd_en) begin
			case (cmd.rd_sel)
				RD_HINT:      cur_q  <= CNT_W'(hint_q);
				RD_IDX:       cur_q  <= CNT_W'(idx_q);
				RD_FIRST:     scan_q <= '0;
				RD_SCAN_NEXT: scan_q <= scan_q + AW'(1);
				default: begin
				end
			endcase
		end
		if (cmd.wr_op == WR_SET_FOUND) begin
			cur_q <= found_idx;
		end
		if (cmd.res_set) begin
			res_ok_q     <= cmd.res_ok;
			res_status_q <= cmd.res_status;
			res_grant_q  <= cmd.res_grant;
		end
		if (cmd.out_load) begin
			out_ok      <= res_ok_q;
			out_granted <= res_grant_q ? cur_q[IDX_W-1:0] : '0;
			out_hint    <= res_grant_q & hit_q;
			out_status  <= res_status_q;
			out_used    <= in_use_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bbah_ctrl.sv =====
// bbah_ctrl: allocator sequencer, steps hint check, word scan, next-block
// check and free through the datapath; depends on bbah_pkg
`default_nettype none

module bbah_ctrl
	import bbah_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_HINT_CHK,
		S_SCAN_CHK,
		S_NEXT,
		S_NEXT_CHK,
		S_FREE_CHK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.mode)
					MODE_ALLOC: begin
						if (stat.full) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_DONE;
						end else if (stat.hint_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_HINT;
							state_d    = S_HINT_CHK;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_FIRST;
							state_d    = S_SCAN_CHK;
						end
					end
					MODE_FREE: begin
						if (stat.empty) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_EMPTY;
							state_d        = S_DONE;
						end else if (stat.idx_oor) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_OOR;
							state_d        = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_IDX;
							state_d    = S_FREE_CHK;
						end
					end
					MODE_CLEAR: begin
						cmd.clear_all  = 1'b1;
						cmd.res_set    = 1'b1;
						cmd.res_ok     = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_ok     = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end
				endcase
			end
			S_HINT_CHK: begin
				if (stat.cur_free) begin
					cmd.wr_op = WR_SET_CUR;
					state_d   = S_NEXT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FIRST;
					state_d    = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (stat.found) begin
					cmd.wr_op = WR_SET_FOUND;
					state_d   = S_NEXT;
				end else if (stat.scan_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NONE;
					state_d        = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SCAN_NEXT;
				end
			end
			S_NEXT: begin
				if (stat.nxt_in_range && !stat.nxt_same_word) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CUR_NEXT;
					state_d    = S_NEXT_CHK;
				end else begin
					cmd.hint_next  = stat.nxt_in_range & stat.nxt_free;
					cmd.res_set    = 1'b1;
					cmd.res_ok     = 1'b1;
					cmd.res_grant  = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end
			end
			S_NEXT_CHK: begin
				cmd.hint_next  = stat.nxt_free;
				cmd.res_set    = 1'b1;
				cmd.res_ok     = 1'b1;
				cmd.res_grant  = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_DONE;
			end
			S_FREE_CHK: begin
				cmd.res_set = 1'b1;
				cmd.res_ok  = 1'b1;
				if (stat.cur_free) begin
					cmd.res_status = ST_DOUBLE;
				end else begin
					cmd.wr_op      = WR_CLR_CUR;
					cmd.res_status = ST_OK;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator_with_hint_core.sv =====
// bitmap_block_allocator_with_hint_core: top level, sequencer plus datapath
// depends on bbah_pkg, bbah_ctrl, bbah_dp
//
// channel   dir  transfer on          payload
// s_*       in   s_tvalid & s_tready  tuser: mode; tdata: block_index
// m_*       out  m_tvalid & m_tready  tdata: ok, granted_index, from_hint, status, used_count
// cfg_*     in   cfg_we               cfg_wdata: block_count
//
// clear, no-op and refused commands finish without reading the bitmap, a free reads it once
// allocate is served by the hint when that block is free; otherwise a scan reads one
// bitmap word at a time through the single read port of the bitmap ram
// (up to 8 words for 256 blocks in 32-bit words)
// reset and clear empty the bitmap at once through per-word valid bits
// a finished result waits in the output register while the next command is taken
`default_nettype none

module bitmap_block_allocator_with_hint_core
	import bbah_pkg::*;
#(
	parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
	parameter int SCAN_WORD_BITS = SCAN_WORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CNT_W-1:0]       cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // block_index
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // mode
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata    // ok, granted_index, from_hint, status, used_count
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             out_ok;
	logic [IDX_W-1:0] out_granted;
	logic             out_hint;
	status_t          out_status;
	logic [CNT_W-1:0] out_used;

	bbah_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bbah_dp #(
		.MAX_BLOCKS    (MAX_BLOCKS),
		.SCAN_WORD_BITS(SCAN_WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mode    (mode_t'(s_tuser)),
		.in_idx     (s_tdata[IDX_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ok     (out_ok),
		.out_granted(out_granted),
		.out_hint   (out_hint),
		.out_status (out_status),
		.out_used   (out_used)
	);

	assign m_tdata = {{(OUT_TDATA_W - OUT_RAW_W){1'b0}},
		out_used, out_status, out_hint, out_granted, out_ok};

endmodule

`default_nettype wire

// ===== hw/rtl/bbah_checker.sv =====
// bbah_checker: port-level checks of the allocator result stream, with bind
// depends on bbah_pkg and bitmap_block_allocator_with_hint_core
`default_nettype none

module bbah_checker
	import bbah_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	logic             ok;
	logic [IDX_W-1:0] granted;
	logic             hint;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] used;

	assign ok      = m_tdata[OUT_OK_LSB];
	assign granted = m_tdata[OUT_GRANT_LSB +: IDX_W];
	assign hint    = m_tdata[OUT_HINT_LSB];
	assign status  = m_tdata[OUT_STATUS_LSB +: ST_W];
	assign used    = m_tdata[OUT_USED_LSB +: CNT_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status <= ST_DOUBLE) &&
			(ok == ((status == ST_OK) || (status == ST_DOUBLE))))
		else $error("ok flag disagrees with status");

	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (hint || (granted != '0)) |-> ok && (status == ST_OK))
		else $error("grant fields set on a result that is no grant");

	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> used <= BLOCK_COUNT_RST)
		else $error("used count above pool size");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_RAW_W] == '0)
		else $error("padding bits set");

endmodule

bind bitmap_block_allocator_with_hint_core bbah_checker u_bbah_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

// ===== bench/bbah_pool_checker.sv =====
// bbah_pool_checker: follows the command, reply and block-count channels of the
// allocator, tracks pool state and compares every reply field; depends on bbah_pkg
module bbah_pool_checker
	import bbah_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CNT_W-1:0]       cfg_wdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // block_index
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // mode
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,   // ok, granted_index, from_hint, status, used_count
	output int unsigned                 pending,
	output int unsigned                 mismatches
);

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] granted;
		logic             from_hint;
		status_t          status;
		logic [CNT_W-1:0] used_count;
	} pool_reply_t;

	logic [MAX_BLOCKS_DEF-1:0] used_map;
	logic [CNT_W-1:0]          in_use;
	logic [IDX_W-1:0]          hint_blk;
	logic [CNT_W-1:0]          pool_size;
	pool_reply_t               awaited_replies[$];
	pool_reply_t               want;
	int unsigned               bad;

	function automatic pool_reply_t apply_pool_command(mode_t op, logic [IDX_W-1:0] idx);
		pool_reply_t r;
		int lim;
		int pick;
		bit hit;
		r = '{ok: 1'b0, granted: '0, from_hint: 1'b0, status: ST_OK, used_count: '0};
		lim = (pool_size > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(pool_size);
		case (op)
			MODE_ALLOC: begin
				if (in_use >= lim) begin
					r.status = ST_FULL;
				end else begin
					hit = (hint_blk < lim) && !used_map[hint_blk];
					pick = lim;
					if (hit) begin
						pick = hint_blk;
					end else begin
						for (int k = lim - 1; k >= 0; k--)
							if (!used_map[k]) pick = k;
					end
					if (pick >= lim) begin
						r.status = ST_NONE;
					end else begin
						used_map[pick] = 1'b1;
						if (pick + 1 < lim && !used_map[pick + 1]) hint_blk = pick + 1;
						in_use = in_use + 1'b1;
						r.ok = 1'b1;
						r.granted = pick[IDX_W-1:0];
						r.from_hint = hit;
					end
				end
			end
			MODE_FREE: begin
				if (in_use == 0) begin
					r.status = ST_EMPTY;
				end else if (idx >= lim) begin
					r.status = ST_OOR;
				end else if (!used_map[idx]) begin
					r.ok = 1'b1;
					r.status = ST_DOUBLE;
				end else begin
					used_map[idx] = 1'b0;
					hint_blk = idx;
					in_use = in_use - 1'b1;
					r.ok = 1'b1;
				end
			end
			MODE_CLEAR: begin
				used_map = '0;
				in_use = '0;
				hint_blk = '0;
				r.ok = 1'b1;
			end
			default: begin
				r.ok = 1'b1;
			end
		endcase
		r.used_count = in_use;
		return r;
	endfunction

	function automatic void check_field(string field, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, got_v);
			bad++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_map = '0;
			in_use = '0;
			hint_blk = '0;
			pool_size = BLOCK_COUNT_RST;
			awaited_replies.delete();
			bad = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) pool_size = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (awaited_replies.size() == 0) begin
					$error("reply transfer with nothing awaited: tdata %h", m_tdata);
					bad++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("ok", want.ok, m_tdata[OUT_OK_LSB]);
					check_field("granted_index", want.granted, m_tdata[OUT_GRANT_LSB +: IDX_W]);
					check_field("from_hint", want.from_hint, m_tdata[OUT_HINT_LSB]);
					check_field("status", want.status, m_tdata[OUT_STATUS_LSB +: ST_W]);
					check_field("used_count", want.used_count, m_tdata[OUT_USED_LSB +: CNT_W]);
				end
			end
			if (s_tvalid && s_tready)
				awaited_replies.push_back(apply_pool_command(mode_t'(s_tuser), s_tdata));
			pending <= awaited_replies.size();
			mismatches <= bad;
		end
	end

endmodule

// ===== bench/tb_bitmap_block_allocator_with_hint_core.sv =====
// tb_bitmap_block_allocator_with_hint_core: drives allocate, free, clear and no-op
// commands and block-count writes into the allocator; needs bbah_pkg, the core and
// bbah_pool_checker, which predicts and compares the replies
module tb_bitmap_block_allocator_with_hint_core
	import bbah_pkg::*;
;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 24;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CNT_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // block_index
	logic [IN_TUSER_W-1:0]  s_tuser;   // mode
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // ok, granted_index, from_hint, status, used_count
	int unsigned            pending;
	int unsigned            mismatches;

	bit               steady;
	bit               hold_req;
	logic [CNT_W-1:0] cur_count;

	bitmap_block_allocator_with_hint_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bbah_pool_checker u_pool_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.pending   (pending),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_command(input mode_t op, input logic [IDX_W-1:0] idx);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= idx;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_count = value;
	endtask

	task automatic random_run(input int items, input int alloc_pct, input int free_pct);
		int lim;
		int r;
		logic [IDX_W-1:0] idx;
		mode_t op;
		lim = (cur_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cur_count);
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (lim > 0 && $urandom_range(0, 4) != 0)
				idx = IDX_W'($urandom_range(0, lim - 1));
			else
				idx = IDX_W'($urandom);
			if (r < alloc_pct)
				op = MODE_ALLOC;
			else if (r < alloc_pct + free_pct)
				op = MODE_FREE;
			else
				op = (r % 2 == 0) ? MODE_CLEAR : MODE_NOP;
			push_command(op, idx);
		end
	endtask

	// reply side: random ready bursts, one long hold-off on request
	initial begin : sink
		int span;
		bit held;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				span = $urandom_range(1, 16);
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("bitmap_block_allocator_with_hint_core verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		steady = 1'b0;
		hold_req = 1'b0;
		cur_count = BLOCK_COUNT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, no-op, hint walk, double frees, clear
		push_command(MODE_FREE, 8'd0);
		push_command(MODE_NOP, 8'hFF);
		push_command(MODE_ALLOC, 8'hFF);
		push_command(MODE_ALLOC, 8'h00);
		push_command(MODE_ALLOC, 8'hA5);
		push_command(MODE_FREE, 8'd1);
		push_command(MODE_FREE, 8'd1);
		push_command(MODE_FREE, 8'd255);
		push_command(MODE_ALLOC, 8'h5A);
		push_command(MODE_ALLOC, 8'h00);
		push_command(MODE_CLEAR, 8'hFF);

		// zero block count
		write_block_count(9'd0);
		push_command(MODE_ALLOC, 8'd0);
		push_command(MODE_FREE, 8'd5);

		// leave the hint above a count set lower later
		write_block_count(9'd256);
		repeat (4) push_command(MODE_ALLOC, 8'd0);
		push_command(MODE_FREE, 8'd1);
		push_command(MODE_FREE, 8'd3);
		write_block_count(9'd3);
		push_command(MODE_ALLOC, 8'd0);
		push_command(MODE_ALLOC, 8'd0);
		write_block_count(9'd2);
		push_command(MODE_FREE, 8'd2);
		write_block_count(9'd0);
		push_command(MODE_FREE, 8'd0);
		push_command(MODE_ALLOC, 8'd0);
		write_block_count(9'd511);
		push_command(MODE_ALLOC, 8'd0);

		write_block_count(9'd8);
		random_run(80, 55, 40);
		write_block_count(9'd1);
		random_run(40, 50, 45);
		write_block_count(9'd256);
		hold_req = 1'b1;
		random_run(260, 80, 17);
		write_block_count(9'd40);
		random_run(100, 55, 40);
		write_block_count(9'd255);
		random_run(100, 60, 35);
		write_block_count(9'd0);
		random_run(20, 50, 45);
		write_block_count(9'd511);
		random_run(100, 60, 35);
		write_block_count(9'd17);
		steady = 1'b1;
		random_run(60, 55, 40);

		wait_idle();
		if (mismatches == 0 && pending == 0)
			$display("bitmap_block_allocator_with_hint_core verification clean");
		else
			$display("bitmap_block_allocator_with_hint_core verification failed");
		$finish;
	end

endmodule
